### rtl/dcpu16_execute_unit_defines.svh
// Assertion macros used by the execute unit top level.
`ifndef DCPU16_EXECUTE_UNIT_DEFINES_SVH
`define DCPU16_EXECUTE_UNIT_DEFINES_SVH

// Clocked assertion, held off during reset
`define DCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion checked at every edge, reset included
`define DCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/dce_pkg.sv
// Package: opcodes, pipeline payload type and division step for the execute unit.
`timescale 1ns / 1ps
package dce_pkg;

    localparam logic [4:0] OP_SET = 5'h01;
    localparam logic [4:0] OP_ADD = 5'h02;
    localparam logic [4:0] OP_SUB = 5'h03;
    localparam logic [4:0] OP_MUL = 5'h04;
    localparam logic [4:0] OP_DIV = 5'h06;
    localparam logic [4:0] OP_MOD = 5'h08;
    localparam logic [4:0] OP_AND = 5'h0A;
    localparam logic [4:0] OP_BOR = 5'h0B;
    localparam logic [4:0] OP_XOR = 5'h0C;
    localparam logic [4:0] OP_SHR = 5'h0D;
    localparam logic [4:0] OP_SHL = 5'h0F;
    localparam logic [4:0] OP_IFB = 5'h10;
    localparam logic [4:0] OP_IFC = 5'h11;
    localparam logic [4:0] OP_IFE = 5'h12;
    localparam logic [4:0] OP_IFN = 5'h13;
    localparam logic [4:0] OP_IFG = 5'h14;
    localparam logic [4:0] OP_IFL = 5'h16;
    localparam logic [4:0] OP_ADX = 5'h1A;
    localparam logic [4:0] OP_STI = 5'h1E;
    localparam logic [4:0] OP_STD = 5'h1F;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_INC  = 2'b01;
    localparam logic [1:0] STEP_DEC  = 2'b11;

    localparam int DIV_STEPS  = 8;
    // Stages needed for the 32-step division, and the stage that ends step sixteen
    localparam int DIV_STAGES = 32 / DIV_STEPS;
    localparam int MOD_STAGE  = 16 / DIV_STEPS - 1;

    // Payload carried down the pipe
    typedef struct packed {
        logic [4:0]  kind;
        logic        a_zero;
        logic [15:0] divisor;
        logic [15:0] rb;
        logic [15:0] rex;
        logic        wb;
        logic        wex;
        logic        skip;
        logic [1:0]  step;
        logic [15:0] rem;
        logic [31:0] dq;
        logic [15:0] mod_rem;
    } pipe_t;

    // One restoring division step: shift in a dividend bit, subtract if it fits
    function automatic logic [47:0] div_step(logic [15:0] rem, logic [31:0] dq,
                                              logic [15:0] d);
        logic [16:0] r;
        logic [31:0] q;
        r = {rem, dq[31]};
        q = {dq[30:0], 1'b0};
        if (r >= {1'b0, d})
        begin
            r    = r - {1'b0, d};
            q[0] = 1'b1;
        end
        return {r[15:0], q};
    endfunction

endpackage

### rtl/dce_decode.sv
// First stage: decode, ALU results and divider set-up, registered.
`timescale 1ns / 1ps
module dce_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [4:0]        kind,
    input  logic [15:0]       value_a,
    input  logic [15:0]       value_b,
    input  logic [15:0]       ex_in,
    output logic              out_valid,
    input  logic              out_ready,
    output dce_pkg::pipe_t    out_data
);

    logic           valid_reg;
    dce_pkg::pipe_t data_reg;
    dce_pkg::pipe_t data_next;
    logic [16:0]    sum;
    logic [17:0]    sum3;
    logic [31:0]    prod;
    logic [31:0]    shl_t;
    logic [31:0]    shr_t;
    logic           wide;

    assign in_ready = !valid_reg || out_ready;

    // Evaluate everything but the division
    always_comb
    begin
        sum   = {1'b0, value_b} + {1'b0, value_a};
        sum3  = {2'b00, value_b} + {2'b00, value_a} + {2'b00, ex_in};
        prod  = value_b * value_a;
        wide  = (value_a[15:5] != 11'd0);
        shl_t = wide ? 32'd0 : ({16'd0, value_b} << value_a[4:0]);
        shr_t = wide ? 32'd0 : ({value_b, 16'd0} >> value_a[4:0]);

        data_next         = '0;
        data_next.kind    = kind;
        data_next.a_zero  = (value_a == 16'd0);
        data_next.divisor = value_a;
        data_next.dq      = {value_b, 16'd0};
        data_next.step    = dce_pkg::STEP_NONE;

        case (kind)
            dce_pkg::OP_SET:
            begin
                data_next.rb = value_a; data_next.wb = 1'b1;
            end
            dce_pkg::OP_ADD:
            begin
                data_next.rb  = sum[15:0]; data_next.wb = 1'b1;
                data_next.rex = {15'd0, sum[16]}; data_next.wex = 1'b1;
            end
            dce_pkg::OP_SUB:
            begin
                data_next.rb  = value_b - value_a; data_next.wb = 1'b1;
                data_next.rex = (value_a > value_b) ? 16'hFFFF : 16'd0;
                data_next.wex = 1'b1;
            end
            dce_pkg::OP_MUL:
            begin
                data_next.rb  = prod[15:0]; data_next.wb = 1'b1;
                data_next.rex = prod[31:16]; data_next.wex = 1'b1;
            end
            dce_pkg::OP_DIV:
            begin
                data_next.wb = 1'b1; data_next.wex = 1'b1;
            end
            dce_pkg::OP_MOD: data_next.wb = 1'b1;
            dce_pkg::OP_AND:
            begin
                data_next.rb = value_b & value_a; data_next.wb = 1'b1;
            end
            dce_pkg::OP_BOR:
            begin
                data_next.rb = value_b | value_a; data_next.wb = 1'b1;
            end
            dce_pkg::OP_XOR:
            begin
                data_next.rb = value_b ^ value_a; data_next.wb = 1'b1;
            end
            dce_pkg::OP_SHR:
            begin
                data_next.rb  = shr_t[31:16]; data_next.wb = 1'b1;
                data_next.rex = shr_t[15:0]; data_next.wex = 1'b1;
            end
            dce_pkg::OP_SHL:
            begin
                data_next.rb  = shl_t[15:0]; data_next.wb = 1'b1;
                data_next.rex = shl_t[31:16]; data_next.wex = 1'b1;
            end
            dce_pkg::OP_IFB: data_next.skip = ((value_b & value_a) == 16'd0);
            dce_pkg::OP_IFC: data_next.skip = ((value_b & value_a) != 16'd0);
            dce_pkg::OP_IFE: data_next.skip = (value_a != value_b);
            dce_pkg::OP_IFN: data_next.skip = (value_a == value_b);
            dce_pkg::OP_IFG: data_next.skip = (value_b <= value_a);
            dce_pkg::OP_IFL: data_next.skip = (value_b >= value_a);
            dce_pkg::OP_ADX:
            begin
                data_next.rb  = sum3[15:0]; data_next.wb = 1'b1;
                data_next.rex = {15'd0, (sum3[17:16] != 2'd0)}; data_next.wex = 1'b1;
            end
            dce_pkg::OP_STI:
            begin
                data_next.rb = value_a; data_next.wb = 1'b1;
                data_next.step = dce_pkg::STEP_INC;
            end
            dce_pkg::OP_STD:
            begin
                data_next.rb = value_a; data_next.wb = 1'b1;
                data_next.step = dce_pkg::STEP_DEC;
            end
            default: data_next.wb = 1'b0;
        endcase
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/dce_div_stage.sv
// Divider stage: eight restoring steps of the long division, registered.
`timescale 1ns / 1ps
module dce_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take_rem,
    input  logic              in_valid,
    output logic              in_ready,
    input  dce_pkg::pipe_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dce_pkg::pipe_t    out_data
);

    logic           valid_reg;
    dce_pkg::pipe_t data_reg;
    dce_pkg::pipe_t data_next;
    logic [47:0]    st;

    assign in_ready = !valid_reg || out_ready;

    // Advance the division by a group of steps
    always_comb
    begin
        data_next = in_data;
        st        = {in_data.rem, in_data.dq};
        for (int i = 0; i < dce_pkg::DIV_STEPS; i++)
            st = dce_pkg::div_step(st[47:32], st[31:0], in_data.divisor);
        data_next.rem = st[47:32];
        data_next.dq  = st[31:0];
        if (take_rem)
            data_next.mod_rem = st[47:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/dcpu16_execute_unit.sv
// Each accepted input beat is registered in the decode/ALU stage, then in each division stage.
// Throughput: one instruction per cycle; a 32-step long division runs as
// four registered stages of eight steps behind the decode/ALU stage.
// Each stage holds its beat under back-pressure and takes a new one when free.
// Reset (rst_n, asynchronous, active low) empties every stage.
`timescale 1ns / 1ps
`include "dcpu16_execute_unit_defines.svh"
module dcpu16_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // kind[4:0], value_a[20:5], value_b[36:21], ex_in[52:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_b[15:0], write_b[16], ex_out[32:17],
                                   // write_ex[33], skip_next[34], index_step[36:35]
);

    logic           v [0:dce_pkg::DIV_STAGES];
    logic           r [0:dce_pkg::DIV_STAGES];
    dce_pkg::pipe_t d [0:dce_pkg::DIV_STAGES];
    dce_pkg::pipe_t f;
    logic [15:0]    result_b;
    logic [15:0]    ex_out;

    dce_decode u_decode (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .kind(s_tdata[4:0]), .value_a(s_tdata[20:5]),
        .value_b(s_tdata[36:21]), .ex_in(s_tdata[52:37]),
        .out_valid(v[0]), .out_ready(r[0]), .out_data(d[0])
    );

    // Division stages; the remainder after sixteen steps is b mod a
    for (genvar g = 0; g < dce_pkg::DIV_STAGES; g++)
    begin : g_div
        dce_div_stage u_stage (
            .clk(clk), .rst_n(rst_n), .take_rem(g == dce_pkg::MOD_STAGE),
            .in_valid(v[g]), .in_ready(r[g]), .in_data(d[g]),
            .out_valid(v[g+1]), .out_ready(r[g+1]), .out_data(d[g+1])
        );
    end

    assign r[dce_pkg::DIV_STAGES] = m_tready;
    assign f                      = d[dce_pkg::DIV_STAGES];

    // Pick the division results for DIV and MOD
    always_comb
    begin
        result_b = f.rb;
        ex_out   = f.rex;
        if (f.kind == dce_pkg::OP_DIV)
        begin
            result_b = f.a_zero ? 16'd0 : f.dq[31:16];
            ex_out   = f.a_zero ? 16'd0 : f.dq[15:0];
        end
        else if (f.kind == dce_pkg::OP_MOD)
            result_b = f.a_zero ? 16'd0 : f.mod_rem;
    end

    assign m_tvalid = v[dce_pkg::DIV_STAGES];
    assign m_tdata  = {3'd0, f.step, f.skip, f.wex, ex_out, f.wb, result_b};

    `DCE_ASSERT(a_skip_no_write, m_tvalid |-> !(m_tdata[34] && (m_tdata[16] || m_tdata[33])),
                "conditional test also writes a register")
    `DCE_ASSERT(a_ex_needs_b, (m_tvalid && m_tdata[33]) |-> m_tdata[16],
                "EX written without b")
    `DCE_ASSERT(a_step_code, m_tvalid |-> (m_tdata[36:35] != 2'b10),
                "invalid index step")

endmodule

### tb/dcpu16_execute_unit_tb.sv
// Self-checking bench for the execute unit: directed table, then random beats against a predictor.
`timescale 1ns / 1ps
module dcpu16_execute_unit_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [1:0]  index_step;
        logic        skip_next;
        logic        write_ex;
        logic [15:0] ex_out;
        logic        write_b;
        logic [15:0] result_b;
    } exec_res_t;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] ex;
        logic        known;
        exec_res_t   res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    exec_res_t   pending_results[$];
    int          fail_count;
    int          beats_out;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    dcpu16_execute_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one instruction
    function automatic exec_res_t execute_op(logic [4:0] kind, logic [15:0] a,
                                             logic [15:0] b, logic [15:0] ex);
        exec_res_t   r;
        logic [31:0] wide;
        logic [31:0] b_hi;
        r    = '0;
        b_hi = {b, 16'h0000};
        case (kind)
            dce_pkg::OP_SET:
            begin
                r.result_b = a; r.write_b = 1'b1;
            end
            dce_pkg::OP_ADD:
            begin
                wide = 32'(b) + 32'(a);
                r.result_b = wide[15:0]; r.write_b = 1'b1;
                r.ex_out = wide[16] ? 16'h0001 : 16'h0000; r.write_ex = 1'b1;
            end
            dce_pkg::OP_SUB:
            begin
                r.result_b = b - a; r.write_b = 1'b1;
                r.ex_out = (a > b) ? 16'hFFFF : 16'h0000; r.write_ex = 1'b1;
            end
            dce_pkg::OP_MUL:
            begin
                wide = 32'(b) * 32'(a);
                r.result_b = wide[15:0]; r.ex_out = wide[31:16];
                r.write_b = 1'b1; r.write_ex = 1'b1;
            end
            dce_pkg::OP_DIV:
            begin
                r.write_b = 1'b1; r.write_ex = 1'b1;
                if (a != 0)
                begin
                    r.result_b = b / a;
                    wide = b_hi / 32'(a);
                    r.ex_out = wide[15:0];
                end
            end
            dce_pkg::OP_MOD:
            begin
                r.write_b = 1'b1;
                if (a != 0) r.result_b = b % a;
            end
            dce_pkg::OP_AND:
            begin
                r.result_b = b & a; r.write_b = 1'b1;
            end
            dce_pkg::OP_BOR:
            begin
                r.result_b = b | a; r.write_b = 1'b1;
            end
            dce_pkg::OP_XOR:
            begin
                r.result_b = b ^ a; r.write_b = 1'b1;
            end
            dce_pkg::OP_SHR:
            begin
                r.write_b = 1'b1; r.write_ex = 1'b1;
                if (a < 32)
                begin
                    wide = 32'(b) >> a;
                    r.result_b = wide[15:0];
                    wide = b_hi >> a;
                    r.ex_out = wide[15:0];
                end
            end
            dce_pkg::OP_SHL:
            begin
                r.write_b = 1'b1; r.write_ex = 1'b1;
                if (a < 32)
                begin
                    wide = 32'(b) << a;
                    r.result_b = wide[15:0]; r.ex_out = wide[31:16];
                end
            end
            dce_pkg::OP_IFB: r.skip_next = ((b & a) == 0);
            dce_pkg::OP_IFC: r.skip_next = ((b & a) != 0);
            dce_pkg::OP_IFE: r.skip_next = (a != b);
            dce_pkg::OP_IFN: r.skip_next = (a == b);
            dce_pkg::OP_IFG: r.skip_next = (b <= a);
            dce_pkg::OP_IFL: r.skip_next = (b >= a);
            dce_pkg::OP_ADX:
            begin
                wide = 32'(b) + 32'(a) + 32'(ex);
                r.result_b = wide[15:0]; r.write_b = 1'b1;
                r.ex_out = (wide > 32'hFFFF) ? 16'h0001 : 16'h0000; r.write_ex = 1'b1;
            end
            dce_pkg::OP_STI:
            begin
                r.result_b = a; r.write_b = 1'b1; r.index_step = dce_pkg::STEP_INC;
            end
            dce_pkg::OP_STD:
            begin
                r.result_b = a; r.write_b = 1'b1; r.index_step = dce_pkg::STEP_DEC;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Offer one beat, hold it until accepted, and queue its expected result
    task automatic send_instr(logic [4:0] kind, logic [15:0] a, logic [15:0] b,
                              logic [15:0] ex, logic known, exec_res_t fixed);
        exec_res_t want;
        want = execute_op(kind, a, b, ex);
        if (known && want !== fixed)
        begin
            $display("%0t: table row kind %h disagrees: table %h predictor %h",
                     $time, kind, fixed, want);
            fail_count++;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ex, b, a, kind};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(want);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Receiver: stall at random, or hold off entirely when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        exec_res_t got;
        exec_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = exec_res_t'(m_tdata[36:0]);
            beats_out++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.result_b !== want.result_b)
                    $display("%0t: result_b expected %h actual %h", $time,
                             want.result_b, got.result_b);
                if (got.write_b !== want.write_b)
                    $display("%0t: write_b expected %b actual %b", $time,
                             want.write_b, got.write_b);
                if (got.ex_out !== want.ex_out)
                    $display("%0t: ex_out expected %h actual %h", $time,
                             want.ex_out, got.ex_out);
                if (got.write_ex !== want.write_ex)
                    $display("%0t: write_ex expected %b actual %b", $time,
                             want.write_ex, got.write_ex);
                if (got.skip_next !== want.skip_next)
                    $display("%0t: skip_next expected %b actual %b", $time,
                             want.skip_next, got.skip_next);
                if (got.index_step !== want.index_step)
                    $display("%0t: index_step expected %b actual %b", $time,
                             want.index_step, got.index_step);
                if (got !== want) fail_count++;
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // Random operand that favours the edges
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(40));
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random opcode: mostly implemented ones, sometimes any five-bit code
    function automatic logic [4:0] pick_kind();
        logic [4:0] ops[20] = '{dce_pkg::OP_SET, dce_pkg::OP_ADD, dce_pkg::OP_SUB,
                                dce_pkg::OP_MUL, dce_pkg::OP_DIV, dce_pkg::OP_MOD,
                                dce_pkg::OP_AND, dce_pkg::OP_BOR, dce_pkg::OP_XOR,
                                dce_pkg::OP_SHR, dce_pkg::OP_SHL, dce_pkg::OP_IFB,
                                dce_pkg::OP_IFC, dce_pkg::OP_IFE, dce_pkg::OP_IFN,
                                dce_pkg::OP_IFG, dce_pkg::OP_IFL, dce_pkg::OP_ADX,
                                dce_pkg::OP_STI, dce_pkg::OP_STD};
        if ($urandom_range(9) == 0)
            return 5'($urandom);
        return ops[$urandom_range(19)];
    endfunction

    // Directed table: extremes, every opcode and the special cases
    stim_row_t rows[] = '{
        '{dce_pkg::OP_SET, 16'hFFFF, 16'h0000, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF}},
        '{dce_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'h0001, 1'b1, 16'hFFFE}},
        '{dce_pkg::OP_SUB, 16'h0001, 16'h0000, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF}},
        '{dce_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'hFFFE, 1'b1, 16'h0001}},
        '{dce_pkg::OP_DIV, 16'h0000, 16'h1234, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'h0000, 1'b1, 16'h0000}},
        '{dce_pkg::OP_DIV, 16'h0003, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_DIV, 16'h0001, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_MOD, 16'h0000, 16'h1234, 16'hFFFF, 1'b1,
          '{2'b00, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000}},
        '{dce_pkg::OP_MOD, 16'h0007, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_AND, 16'hF0F0, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_BOR, 16'h0F0F, 16'hF000, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_XOR, 16'hFFFF, 16'hAAAA, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_SHR, 16'h0020, 16'hFFFF, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'h0000, 1'b1, 16'h0000}},
        '{dce_pkg::OP_SHR, 16'h0004, 16'h1234, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_SHL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'h0000, 1'b1, 16'h0000}},
        '{dce_pkg::OP_SHL, 16'h001F, 16'h0001, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFB, 16'h00F0, 16'h000F, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFC, 16'h00F0, 16'h0010, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFG, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_IFL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{dce_pkg::OP_ADX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{2'b00, 1'b0, 1'b1, 16'h0001, 1'b1, 16'hFFFD}},
        '{dce_pkg::OP_STI, 16'hABCD, 16'h0000, 16'h0000, 1'b1,
          '{2'b01, 1'b0, 1'b0, 16'h0000, 1'b1, 16'hABCD}},
        '{dce_pkg::OP_STD, 16'h1234, 16'h0000, 16'h0000, 1'b1,
          '{2'b11, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h1234}},
        '{5'h15,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0}
    };

    // Main sequence
    initial
    begin
        int wait_cycles;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        hold_off    = 1'b0;
        fail_count  = 0;
        beats_out   = 0;
        idle_cycles = 0;
        set_idling(0, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_instr(rows[i].kind, rows[i].a, rows[i].b, rows[i].ex,
                       rows[i].known, rows[i].res);

        // Long hold-off on the receiver so the pipe fills and stalls its input
        fork
            begin
                hold_off = 1'b1;
                repeat (40) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_instr(pick_kind(), pick_operand(), pick_operand(), pick_operand(),
                           1'b0, '0);
        join

        // Random phases with differing idling
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i / 120)
                0: set_idling(0, 0);
                1: set_idling(66, 0);
                2: set_idling(0, 66);
                3: set_idling(15, 15);
                default: set_idling(0, 0);
            endcase
            send_instr(pick_kind(), pick_operand(), pick_operand(), pick_operand(),
                       1'b0, '0);
        end
        s_tvalid <= 1'b0;
        set_idling(0, 0);

        // Drain, then watch for stray beats before the report
        while (pending_results.size() != 0) @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < DRAIN_CYCLES)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Ran %0d directed rows and %0d random instructions; %0d results checked.",
                 rows.size(), RANDOM_ITEMS + 20, beats_out);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dce_pkg.sv
rtl/dce_decode.sv
rtl/dce_div_stage.sv
rtl/dcpu16_execute_unit.sv
tb/dcpu16_execute_unit_tb.sv
